// ----- rtl/tscb_pkg.sv -----
`timescale 1ns / 1ps

package tscb_pkg;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_BUNDLE = 2'd1,
    CMD_RESET  = 2'd2,
    CMD_PING   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_UPDATE = 3'd0,
    KIND_ENTRY  = 3'd1,
    KIND_END    = 3'd2,
    KIND_RESET  = 3'd3,
    KIND_PONG   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_END
  } state_e;

  localparam logic [15:0] FRESH_WINDOW_RESET = 16'd50;

  typedef struct packed {
    cmd_e               command;
    logic [7:0]         trk_id;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [7:0]         battery_level;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic               dropped;
    logic [7:0]         out_trk_id;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic [7:0]         out_battery;
    logic [2:0]         entry_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [7:0]         tracker;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [7:0]         battery;
    logic [31:0]        stamp;
  } slot_t;

endpackage

// ----- rtl/tscb_ram.sv -----
`timescale 1ns / 1ps

module tscb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tracker_slot_cache_bundler.sv -----
`timescale 1ns / 1ps

// channel | ports                          | handshake
// --------+--------------------------------+-----------------------------------
// command | start_i, busy_o, cmd_i         | taken when start_i and not busy_o
// result  | valid_o, res_o                 | one-cycle strobe, no back-pressure
// config  | cfg_we_i, cfg_data_i           | fresh window written when cfg_we_i
//
// update and bundle commands walk the slot table through one ram read port,
// one slot a cycle.
// a bundle stops early once MAX_BUNDLE_ENTRIES entries are out, then sends its end.
// reset table and ping answer in the cycle after they are taken, no busy time.
// a reset command clears the valid marks; the fresh window returns to 50 only on rst_ni.
// results are never stalled; each shows on res_o for one cycle with valid_o.

module tracker_slot_cache_bundler #(
  parameter int SLOT_COUNT         = 24,
  parameter int MAX_BUNDLE_ENTRIES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  tscb_pkg::item_t   cmd_i,
  output logic             valid_o,
  output tscb_pkg::result_t res_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i
);

  import tscb_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IW = $clog2(SLOT_COUNT + 1);

  state_e                state_q, state_d;
  item_t                 item_q, item_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  chk_q, chk_d;
  logic [AW-1:0]         chk_idx_q, chk_idx_d;
  logic                  free_found_q, free_found_d;
  logic [AW-1:0]         free_idx_q, free_idx_d;
  logic [2:0]            count_q, count_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [15:0]           window_q;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  slot_t                 ram_wdata;
  slot_t                 rd_slot;
  logic [31:0]           age;
  logic                  slot_ok;

  tscb_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_slot)
  );

  always_comb begin
    ram_wdata.tracker = item_q.trk_id;
    ram_wdata.quat_w  = item_q.quat_w;
    ram_wdata.quat_x  = item_q.quat_x;
    ram_wdata.quat_y  = item_q.quat_y;
    ram_wdata.quat_z  = item_q.quat_z;
    ram_wdata.battery = item_q.battery_level;
    ram_wdata.stamp   = item_q.now_ms;
  end

  // shared compare unit: id match on updates, age check on bundles
  assign age     = item_q.now_ms - rd_slot.stamp;
  assign slot_ok = (item_q.command == CMD_UPDATE) ? (rd_slot.tracker == item_q.trk_id)
                                                  : (age < {16'd0, window_q});

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    chk_d        = 1'b0;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    count_d      = count_q;
    valid_d      = valid_q;
    out_valid_d  = 1'b0;
    out_d        = '0;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d = cmd_i;
          unique case (cmd_i.command) inside
            CMD_UPDATE, CMD_BUNDLE: begin
              state_d      = ST_WALK;
              idx_d        = '0;
              count_d      = '0;
              free_found_d = 1'b0;
            end
            CMD_RESET: begin
              valid_d     = '0;
              out_valid_d = 1'b1;
              out_d.kind  = KIND_RESET;
              out_d.last  = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
              out_d.kind  = KIND_PONG;
              out_d.last  = 1'b1;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (idx_q < IW'(SLOT_COUNT)) begin
          idx_d     = idx_q + IW'(1);
          chk_d     = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
        end

        if (chk_q) begin
          if (item_q.command == CMD_UPDATE) begin
            if (valid_q[chk_idx_q] && slot_ok) begin
              ram_we      = 1'b1;
              ram_waddr   = chk_idx_q;
              out_valid_d = 1'b1;
              out_d.kind  = KIND_UPDATE;
              out_d.last  = 1'b1;
              state_d     = ST_IDLE;
            end else if (!valid_q[chk_idx_q] && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = chk_idx_q;
            end
          end else if (valid_q[chk_idx_q] && slot_ok) begin
            out_valid_d          = 1'b1;
            out_d.kind           = KIND_ENTRY;
            out_d.out_trk_id     = rd_slot.tracker;
            out_d.out_quat_w     = rd_slot.quat_w;
            out_d.out_quat_x     = rd_slot.quat_x;
            out_d.out_quat_y     = rd_slot.quat_y;
            out_d.out_quat_z     = rd_slot.quat_z;
            out_d.out_battery    = rd_slot.battery;
            count_d              = count_q + 3'd1;
            if (count_d == 3'(MAX_BUNDLE_ENTRIES)) begin
              state_d = ST_END;
            end
          end
        end else if (idx_q == IW'(SLOT_COUNT)) begin
          out_valid_d = 1'b1;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
          if (item_q.command == CMD_UPDATE) begin
            out_d.kind = KIND_UPDATE;
            if (free_found_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
            end else begin
              out_d.dropped = 1'b1;
            end
          end else begin
            out_d.kind        = KIND_END;
            out_d.entry_count = count_q;
          end
        end

        if (ram_we) begin
          valid_d[ram_waddr] = 1'b1;
        end
      end

      ST_END: begin
        out_valid_d       = 1'b1;
        out_d.kind        = KIND_END;
        out_d.entry_count = count_q;
        out_d.last        = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_q       <= 1'b0;
      valid_q     <= '0;
      window_q    <= FRESH_WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    idx_q        <= idx_d;
    chk_idx_q    <= chk_idx_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    count_q      <= count_d;
    out_q        <= out_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule
